### rtl/rudp_pkg.sv
// Package for the reliable-UDP packet validator.
// Item, configuration types, error codes and checksum constants; no dependencies.
package rudp_pkg;

	localparam logic [15:0] CHK_EMPTY_PAYLOAD = 16'h1234;
	localparam logic [15:0] CHK_ALL_ONES      = 16'hffff;

	localparam logic [2:0] ERR_NONE      = 3'd0;
	localparam logic [2:0] ERR_NO_FLAGS  = 3'd1;
	localparam logic [2:0] ERR_CHECKSUM  = 3'd2;
	localparam logic [2:0] ERR_EXCLUSIVE = 3'd3;
	localparam logic [2:0] ERR_EACK      = 3'd4;

	localparam logic [1:0] REG_EXCLUSIVE_MASK = 2'd0;
	localparam logic [1:0] REG_ACK_MASK       = 2'd1;
	localparam logic [1:0] REG_EACK_MASK      = 2'd2;

	typedef struct packed {
		logic [7:0]  flags;
		logic [15:0] header_checksum;
		logic [7:0]  payload_byte;
		logic        byte_valid;
		logic        last;
	} item_t;

	typedef struct packed {
		logic [7:0] exclusive_mask;
		logic [7:0] ack_mask;
		logic [7:0] eack_mask;
	} cfg_t;

endpackage

### rtl/rudp_in_stage.sv
// Input register stage of the packet validator.
// Holds one request until the checksum core takes it; uses rudp_pkg.
module rudp_in_stage import rudp_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  in_valid,
	output logic  in_ready,
	input  item_t item,
	input  logic  take,
	output logic  valid_s1,
	output item_t item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= item;
		end
	end

endmodule

### rtl/rudp_csum_core.sv
// Checksum accumulator and packet checks of the packet validator.
// Per-packet state and result register; uses rudp_pkg.
module rudp_csum_core import rudp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        valid_s1,
	input  item_t       item_s1,
	input  cfg_t        cfg,
	output logic        take,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        packet_ok,
	output logic [2:0]  error_code,
	output logic [15:0] computed_checksum
);

	logic [15:0] run_q;
	logic [7:0]  held_q;
	logic        pend_q;
	logic        saw_q;
	logic        out_valid_q;

	logic        pair;
	logic        do_add;
	logic [15:0] addend;
	logic [16:0] sum17;
	logic [15:0] sum_wrap;
	logic [15:0] new_sum;
	logic [15:0] computed;
	logic        saw;
	logic [7:0]  excl;
	logic [15:0] expect_chk;
	logic [2:0]  err;

	// a last item needs the result slot free, others only touch the state
	assign take = valid_s1 && (!item_s1.last || !out_valid_q || out_ready);

	// at most one add per item: a trailing odd byte never coincides with a pair
	always_comb begin
		pair   = item_s1.byte_valid && pend_q;
		do_add = pair || (item_s1.last && (item_s1.byte_valid || pend_q));
		if (pair) begin
			addend = {item_s1.payload_byte, held_q};
		end else begin
			addend = {8'h00, item_s1.byte_valid ? item_s1.payload_byte : held_q};
		end
		sum17    = {1'b0, run_q} + {1'b0, addend};
		sum_wrap = sum17[15:0] + {15'd0, sum17[16]};
		new_sum  = do_add ? sum_wrap : run_q;
		computed = ~new_sum;
		saw      = saw_q || item_s1.byte_valid;
	end

	always_comb begin
		excl       = item_s1.flags & cfg.exclusive_mask;
		expect_chk = saw ? computed : CHK_EMPTY_PAYLOAD;
		priority if (item_s1.flags == 8'h00) begin
			err = ERR_NO_FLAGS;
		end else if (item_s1.header_checksum != expect_chk) begin
			err = ERR_CHECKSUM;
		end else if ((excl & (excl - 8'd1)) != 8'h00) begin
			err = ERR_EXCLUSIVE;
		end else if ((item_s1.flags & cfg.eack_mask) != 8'h00 &&
				(item_s1.flags & cfg.ack_mask) == 8'h00) begin
			err = ERR_EACK;
		end else begin
			err = ERR_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 16'h0000;
			held_q <= 8'h00;
			pend_q <= 1'b0;
			saw_q  <= 1'b0;
		end else if (take) begin
			if (item_s1.last) begin
				run_q  <= 16'h0000;
				held_q <= 8'h00;
				pend_q <= 1'b0;
				saw_q  <= 1'b0;
			end else begin
				run_q <= new_sum;
				saw_q <= saw;
				if (item_s1.byte_valid) begin
					pend_q <= !pend_q;
					held_q <= pend_q ? 8'h00 : item_s1.payload_byte;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (take && item_s1.last) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && item_s1.last) begin
			packet_ok         <= (err == ERR_NONE);
			error_code        <= err;
			computed_checksum <= computed;
		end
	end

	assign out_valid = out_valid_q;

endmodule

### rtl/rudp_packet_validator.sv
// Top level of the reliable-UDP packet validator.
// Configuration registers and the two stages; uses rudp_pkg, rudp_in_stage, rudp_csum_core.
//
// Takes one payload byte per request, one request per clock while no last request
// waits on a full result register, with no bubbles between packets. A request passes
// an input register, then a single 16-bit end-around-carry add updates the running
// ones' complement sum; on the request marked last the checks are evaluated in the
// same cycle and the verdict lands in the result register as out_valid rises. A waiting
// result does not stop non-final bytes; only a last request waits for the result
// register to drain. Masks are written through cfg_we/cfg_index/cfg_data; index 3
// is ignored.
module rudp_packet_validator import rudp_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  flags,
	input  logic [15:0] header_checksum,
	input  logic [7:0]  payload_byte,
	input  logic        byte_valid,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        packet_ok,
	output logic [2:0]  error_code,
	output logic [15:0] computed_checksum,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [7:0]  cfg_data
);

	cfg_t  cfg_q;
	item_t item;
	item_t item_s1;
	logic  valid_s1;
	logic  take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_EXCLUSIVE_MASK: cfg_q.exclusive_mask <= cfg_data;
				REG_ACK_MASK:       cfg_q.ack_mask       <= cfg_data;
				REG_EACK_MASK:      cfg_q.eack_mask      <= cfg_data;
				default:            cfg_q                <= cfg_q;
			endcase
		end
	end

	assign item = '{
		flags:           flags,
		header_checksum: header_checksum,
		payload_byte:    payload_byte,
		byte_valid:      byte_valid,
		last:            last
	};

	rudp_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.item     (item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	rudp_csum_core u_csum_core (
		.clk               (clk),
		.arst_n            (arst_n),
		.valid_s1          (valid_s1),
		.item_s1           (item_s1),
		.cfg               (cfg_q),
		.take              (take),
		.out_valid         (out_valid),
		.out_ready         (out_ready),
		.packet_ok         (packet_ok),
		.error_code        (error_code),
		.computed_checksum (computed_checksum)
	);

endmodule

### test/rudp_packet_validator_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for rudp_packet_validator: payload checksum and packet verdicts.
// Needs rudp_pkg and the validator RTL; predicts each verdict with its own scoreboard model.
module rudp_packet_validator_tb;
	import rudp_pkg::*;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int SETTLE_CYCLES = 8;
	localparam int SEG_ITEMS = 325;
	localparam int MAX_PRINTED = 40;

	typedef logic [7:0] byte_q_t[$];

	typedef struct packed {
		logic        ok;
		logic [2:0]  code;
		logic [15:0] csum;
	} verdict_t;

	class verdict_scoreboard;
		cfg_t        masks;
		logic [15:0] word_sum;
		logic [7:0]  low_byte;
		logic        low_pending;
		logic        any_payload;
		verdict_t    pending_verdicts[$];
		int          errors;
		int          checked;
		int          code_seen[8];

		function new();
			masks = '0;
			errors = 0;
			checked = 0;
			foreach (code_seen[i]) code_seen[i] = 0;
			clear_packet();
		endfunction

		function void clear_packet();
			word_sum = '0;
			low_byte = '0;
			low_pending = 1'b0;
			any_payload = 1'b0;
		endfunction

		function void write_reg(logic [1:0] index, logic [7:0] value);
			case (index)
				REG_EXCLUSIVE_MASK: masks.exclusive_mask = value;
				REG_ACK_MASK:       masks.ack_mask = value;
				REG_EACK_MASK:      masks.eack_mask = value;
				default: ;
			endcase
		endfunction

		function logic [15:0] end_around_add(logic [15:0] a, logic [15:0] b);
			logic [16:0] s;
			s = a + b;
			return s[15:0] + s[16];
		endfunction

		function void note_request(item_t req);
			verdict_t v;
			if (req.byte_valid) begin
				any_payload = 1'b1;
				if (low_pending) begin
					word_sum = end_around_add(word_sum, {req.payload_byte, low_byte});
					low_byte = '0;
					low_pending = 1'b0;
				end else begin
					low_byte = req.payload_byte;
					low_pending = 1'b1;
				end
			end
			if (!req.last)
				return;
			// a dangling odd byte counts as a low byte
			if (low_pending)
				word_sum = end_around_add(word_sum, {8'h00, low_byte});
			v.csum = ~word_sum;
			if (req.flags == 8'h00)
				v.code = ERR_NO_FLAGS;
			else if (req.header_checksum != (any_payload ? v.csum : CHK_EMPTY_PAYLOAD))
				v.code = ERR_CHECKSUM;
			else if ($countones(req.flags & masks.exclusive_mask) > 1)
				v.code = ERR_EXCLUSIVE;
			else if ((req.flags & masks.eack_mask) != 0 && (req.flags & masks.ack_mask) == 0)
				v.code = ERR_EACK;
			else
				v.code = ERR_NONE;
			v.ok = (v.code == ERR_NONE);
			pending_verdicts.push_back(v);
			clear_packet();
		endfunction

		task report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("mismatch at %0t: %s", $time, msg);
		endtask

		task check_verdict(logic ok, logic [2:0] code, logic [15:0] csum);
			verdict_t want;
			checked++;
			if (pending_verdicts.size() == 0) begin
				report($sformatf("unexpected verdict ok=%0b code=%0d csum=%h", ok, code, csum));
				return;
			end
			want = pending_verdicts.pop_front();
			code_seen[want.code]++;
			if (ok !== want.ok)
				report($sformatf("packet_ok %0b, want %0b", ok, want.ok));
			if (code !== want.code)
				report($sformatf("error_code %0d, want %0d", code, want.code));
			if (csum !== want.csum)
				report($sformatf("computed_checksum %h, want %h", csum, want.csum));
		endtask
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  flags = '0;
	logic [15:0] header_checksum = '0;
	logic [7:0]  payload_byte = '0;
	logic        byte_valid = 1'b0;
	logic        last = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic        packet_ok;
	logic [2:0]  error_code;
	logic [15:0] computed_checksum;
	logic        cfg_we = 1'b0;
	logic [1:0]  cfg_index = '0;
	logic [7:0]  cfg_data = '0;

	verdict_scoreboard sb = new();
	cfg_t live_masks = '0;
	int   send_idle_pct = 0;
	int   recv_idle_pct = 0;
	int   hold_len = 0;
	int   items_accepted = 0;
	int   packets_sent = 0;

	rudp_packet_validator dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// receiver: random stalls, or a counted hold-off when asked
	always @(posedge clk) begin
		if (hold_len > 0) begin
			hold_len = hold_len - 1;
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(99) >= recv_idle_pct);
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_verdict(packet_ok, error_code, computed_checksum);
	end

	initial begin
		#1_000_000;
		$display("TB_ERROR");
		$finish;
	end

	function automatic logic [15:0] payload_checksum(byte_q_t bytes);
		int unsigned total;
		total = 0;
		for (int i = 0; i < bytes.size(); i += 2)
			total += bytes[i] + ((i + 1 < bytes.size()) ? (int'(bytes[i + 1]) << 8) : 0);
		while (total >> 16)
			total = (total & 32'hffff) + (total >> 16);
		return ~total[15:0];
	endfunction

	task automatic send_req(input item_t req);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		flags <= req.flags;
		header_checksum <= req.header_checksum;
		payload_byte <= req.payload_byte;
		byte_valid <= req.byte_valid;
		last <= req.last;
		do @(posedge clk); while (!in_ready);
		sb.note_request(req);
		items_accepted++;
	endtask

	// fill_pct inserts invalid bytes; noisy puts junk header fields on early requests
	task automatic send_packet(input logic [7:0] pkt_flags, input logic [15:0] hdr,
			input byte_q_t bytes, input int fill_pct, input bit noisy);
		item_t reqs[$];
		item_t r;
		foreach (bytes[i]) begin
			while ($urandom_range(99) < fill_pct) begin
				r = '0;
				r.payload_byte = 8'($urandom);
				reqs.push_back(r);
			end
			r = '0;
			r.payload_byte = bytes[i];
			r.byte_valid = 1'b1;
			reqs.push_back(r);
		end
		if (bytes.size() == 0 || $urandom_range(9) == 0) begin
			r = '0;
			r.payload_byte = 8'($urandom);
			reqs.push_back(r);
		end
		foreach (reqs[i]) begin
			if (i == reqs.size() - 1) begin
				reqs[i].flags = pkt_flags;
				reqs[i].header_checksum = hdr;
				reqs[i].last = 1'b1;
			end else begin
				reqs[i].flags = noisy ? 8'($urandom) : pkt_flags;
				reqs[i].header_checksum = noisy ? 16'($urandom) : hdr;
			end
		end
		foreach (reqs[i])
			send_req(reqs[i]);
		packets_sent++;
	endtask

	task automatic drain_results();
		in_valid <= 1'b0;
		while (sb.pending_verdicts.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(input logic [1:0] index, input logic [7:0] value);
		cfg_we <= 1'b1;
		cfg_index <= index;
		cfg_data <= value;
		@(posedge clk);
		sb.write_reg(index, value);
	endtask

	task automatic reconfigure(input logic [7:0] excl, input logic [7:0] ack,
			input logic [7:0] eack);
		drain_results();
		write_reg(REG_EXCLUSIVE_MASK, excl);
		write_reg(REG_ACK_MASK, ack);
		write_reg(REG_EACK_MASK, eack);
		write_reg(REG_UNUSED, 8'($urandom));
		cfg_we <= 1'b0;
		live_masks = '{excl, ack, eack};
	endtask

	task automatic random_traffic(input int n_items);
		byte_q_t     bytes;
		int          stop_at;
		int          len;
		int          r;
		logic [7:0]  f;
		logic [15:0] hdr;
		stop_at = items_accepted + n_items;
		while (items_accepted < stop_at) begin
			r = $urandom_range(99);
			len = r < 8 ? 0 : r < 85 ? $urandom_range(12, 1) :
				r < 97 ? $urandom_range(40, 13) : $urandom_range(200, 41);
			bytes = {};
			repeat (len) bytes.push_back(8'($urandom));
			r = $urandom_range(99);
			if (r < 8)
				f = 8'h00;
			else if (r < 55)
				f = (8'h01 << $urandom_range(7)) | ($urandom_range(1) ? live_masks.ack_mask : 8'h00);
			else
				f = 8'($urandom);
			if ($urandom_range(99) < 85)
				hdr = (len == 0) ? CHK_EMPTY_PAYLOAD : payload_checksum(bytes);
			else
				hdr = 16'($urandom);
			send_packet(f, hdr, bytes, ($urandom_range(3) == 0) ? 20 : 0, $urandom_range(9) == 0);
		end
	endtask

	initial begin
		byte_q_t bytes;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 25;
		recv_idle_pct = 69;
		// masks are zero after reset: only no-flags and checksum errors possible
		bytes = {};
		send_packet(8'h01, CHK_EMPTY_PAYLOAD, bytes, 0, 0);
		send_packet(8'h80, 16'h1235, bytes, 0, 0);
		bytes = '{8'h5a};
		send_packet(8'h00, payload_checksum(bytes), bytes, 0, 0);
		bytes = '{8'hff};
		send_packet(8'hff, payload_checksum(bytes), bytes, 0, 0);
		bytes = '{8'hff, 8'hff, 8'hff, 8'hff};
		send_packet(8'h42, payload_checksum(bytes), bytes, 0, 0);
		// invalid byte mid-packet, junk header on early requests, invalid last
		send_req(item_t'{8'h00, 16'hdead, 8'h00, 1'b1, 1'b0});
		send_req(item_t'{8'hff, 16'hbeef, 8'hff, 1'b0, 1'b0});
		send_req(item_t'{8'h11, 16'h0000, 8'h01, 1'b1, 1'b0});
		send_req(item_t'{8'h04, 16'hfeff, 8'hab, 1'b0, 1'b1});
		packets_sent++;

		reconfigure(8'h0f, 8'h10, 8'h20);
		bytes = {};
		send_packet(8'h03, CHK_EMPTY_PAYLOAD, bytes, 0, 0);
		send_packet(8'h20, CHK_EMPTY_PAYLOAD, bytes, 0, 0);
		send_packet(8'h31, CHK_EMPTY_PAYLOAD, bytes, 0, 0);
		send_packet(8'h03, 16'h0000, bytes, 0, 0);
		send_packet(8'h00, 16'h0000, bytes, 0, 0);
		bytes = '{8'h12, 8'h34, 8'h56};
		send_packet(8'h10, payload_checksum(bytes), bytes, 0, 0);

		for (int seg = 0; seg < 6; seg++) begin
			send_idle_pct = seg < 2 ? 25 : seg < 4 ? 69 : 0;
			recv_idle_pct = seg < 2 ? 69 : seg < 4 ? 25 : 0;
			case (seg)
				0: reconfigure(8'hff, 8'hff, 8'hff);
				1: reconfigure(8'h00, 8'h00, 8'hff);
				3: reconfigure(8'hff, 8'h01, 8'h02);
				5: reconfigure(8'h00, 8'hff, 8'h00);
				default: reconfigure(8'($urandom), 8'($urandom), 8'($urandom));
			endcase
			// long hold-off so verdicts back up and last requests stall
			if (seg == 1 || seg == 4)
				hold_len = 400;
			if (seg == 2) begin
				random_traffic(SEG_ITEMS / 2);
				drain_results();
				random_traffic(SEG_ITEMS - SEG_ITEMS / 2);
			end else begin
				random_traffic(SEG_ITEMS);
			end
		end

		drain_results();
		$display("ran %0d requests in %0d packets over six mask settings and three idle mixes",
			items_accepted, packets_sent);
		$display("verdicts %0d: ok %0d, no flags %0d, checksum %0d, exclusive %0d, eack %0d",
			sb.checked, sb.code_seen[ERR_NONE], sb.code_seen[ERR_NO_FLAGS],
			sb.code_seen[ERR_CHECKSUM], sb.code_seen[ERR_EXCLUSIVE], sb.code_seen[ERR_EACK]);
		if (sb.errors == 0 && sb.pending_verdicts.size() == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule
